@@ src/orm_pkg.sv @@
// Shared constants, payload and control types, and helpers for the occupancy rate map.
package orm_pkg;

   // Map geometry and counter sizes.
   localparam int MAP_DIM     = 64;
   localparam int COUNT_WIDTH = 32;
   localparam int CELLS       = MAP_DIM * MAP_DIM;
   localparam int ADDR_W      = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int MEM_W       = 2 * COUNT_WIDTH;

   // Field widths fixed by the interface.
   localparam int COORD_W     = 8;
   localparam int SPS_W       = 16;
   localparam int OUT_W       = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Rate arithmetic: spikes times sampling rate, then Q24.8 quotient.
   localparam int PROD_W      = COUNT_WIDTH + SPS_W;
   localparam int RATE_FRAC   = 8;
   localparam int SAT_SHIFT   = OUT_W - RATE_FRAC;
   localparam int DIV_CNT_W   = 6;
   localparam int BIN_STEPS   = COORD_W;
   localparam int RATE_STEPS  = OUT_W;

   // Command codes.
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_REDUCE_X   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REDUCE_Y   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPS        = 3'd4;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [7:0] spike_count;
      logic [5:0] cell_col;
      logic [5:0] cell_row;
   } orm_req_type;

   typedef struct packed {
      logic [31:0] rate_q8;
      logic        visited;
      logic [31:0] occupancy;
      logic [31:0] spike_total;
   } orm_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic start_x;
      logic start_y;
      logic cap_col;
      logic cap_row;
      logic mem_read;
      logic mem_update;
      logic load_counts;
      logic load_product;
      logic start_rate;
      logic load_result;
      logic clear_write;
   } orm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] command;
      logic       div_busy;
      logic       in_area;
      logic       clear_last;
   } orm_status_type;

   // Clamp a counter to the 32-bit result field.
   function automatic logic [OUT_W-1:0] sat_out(input logic [COUNT_WIDTH-1:0] v);
      logic [63:0] wide;
      wide = 64'(v);
      if (wide > 64'h0000_0000_FFFF_FFFF) begin
         return '1;
      end
      return OUT_W'(v);
   endfunction

endpackage

@@ src/orm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module orm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/orm_datapath.sv @@
// Datapath: registers, binning and rate divider, counter store and result register.
module orm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [orm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [orm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  orm_pkg::orm_req_type                req_data,
   input  orm_pkg::orm_cmd_type                cmd,
   output orm_pkg::orm_status_type             status,
   output orm_pkg::orm_rsp_type                rsp_data
);
   import orm_pkg::*;

   logic [7:0]             reduce_x_ff;
   logic [7:0]             reduce_y_ff;
   logic [6:0]             map_width_ff;
   logic [6:0]             map_height_ff;
   logic [SPS_W-1:0]       sps_ff;

   logic [1:0]             command_ff;
   logic [COORD_W-1:0]     pos_x_ff;
   logic [COORD_W-1:0]     pos_y_ff;
   logic [7:0]             spike_ff;
   logic [COORD_W-1:0]     col_ff;
   logic [COORD_W-1:0]     row_ff;

   logic [COUNT_WIDTH-1:0] div_rem_ff;
   logic [OUT_W-1:0]       div_quo_ff;
   logic [COUNT_WIDTH-1:0] div_den_ff;
   logic [DIV_CNT_W-1:0]   div_cnt_ff;
   logic                   div_busy_ff;
   logic [COUNT_WIDTH:0]   rem_shift;
   logic                   rem_fits;
   logic [COUNT_WIDTH-1:0] rem_in;

   logic [COUNT_WIDTH-1:0] occ_ff;
   logic [COUNT_WIDTH-1:0] spk_ff;
   logic [PROD_W-1:0]      prod_ff;
   orm_rsp_type            rsp_ff;

   logic [ADDR_W-1:0]      clr_addr_ff;
   logic                   clear_last;

   logic [7:0]             div_x;
   logic [7:0]             div_y;
   logic                   in_area;
   logic [ADDR_W-1:0]      cell_addr;

   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [MEM_W-1:0]       wr_data;
   logic [MEM_W-1:0]       rd_data;
   logic [COUNT_WIDTH-1:0] occ_rd;
   logic [COUNT_WIDTH-1:0] spk_rd;
   logic [COUNT_WIDTH:0]   occ_sum;
   logic [COUNT_WIDTH:0]   spk_sum;
   logic [COUNT_WIDTH-1:0] occ_new;
   logic [COUNT_WIDTH-1:0] spk_new;
   logic                   rate_sat;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         reduce_x_ff   <= 8'd4;
         reduce_y_ff   <= 8'd4;
         map_width_ff  <= 7'd64;
         map_height_ff <= 7'd64;
         sps_ff        <= 16'd30;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REDUCE_X:   reduce_x_ff   <= csr_wdata[7:0];
            CSR_REDUCE_Y:   reduce_y_ff   <= csr_wdata[7:0];
            CSR_MAP_WIDTH:  map_width_ff  <= csr_wdata[6:0];
            CSR_MAP_HEIGHT: map_height_ff <= csr_wdata[6:0];
            CSR_SPS:        sps_ff        <= csr_wdata[SPS_W-1:0];
            default: ;
         endcase
      end
   end

   // Request capture; a read takes its cell directly, a sample gets it from the divider.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         command_ff <= req_data.command;
         pos_x_ff   <= req_data.pos_x;
         pos_y_ff   <= req_data.pos_y;
         spike_ff   <= req_data.spike_count;
         col_ff     <= COORD_W'(req_data.cell_col);
         row_ff     <= COORD_W'(req_data.cell_row);
      end else begin
         if (cmd.cap_col) begin
            col_ff <= div_quo_ff[COORD_W-1:0];
         end
         if (cmd.cap_row) begin
            row_ff <= div_quo_ff[COORD_W-1:0];
         end
      end
   end

   // A reduce factor of zero divides by one.
   assign div_x = (reduce_x_ff == 8'd0) ? 8'd1 : reduce_x_ff;
   assign div_y = (reduce_y_ff == 8'd0) ? 8'd1 : reduce_y_ff;

   // One restoring division step: shift the next dividend bit in, subtract if it fits.
   always_comb begin
      rem_shift = {div_rem_ff, div_quo_ff[OUT_W-1]};
      rem_fits  = rem_shift >= {1'b0, div_den_ff};
      if (rem_fits) begin
         rem_in = COUNT_WIDTH'(rem_shift - {1'b0, div_den_ff});
      end else begin
         rem_in = rem_shift[COUNT_WIDTH-1:0];
      end
   end

   // Shared divider control: bin columns, bin rows and the rate quotient.
   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (cmd.start_x || cmd.start_y) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= DIV_CNT_W'(BIN_STEPS);
      end else if (cmd.start_rate) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= DIV_CNT_W'(RATE_STEPS);
      end else if (div_busy_ff) begin
         div_busy_ff <= (div_cnt_ff != DIV_CNT_W'(1));
         div_cnt_ff  <= div_cnt_ff - DIV_CNT_W'(1);
      end
   end

   // Divider data registers.
   always_ff @(posedge clock) begin
      if (cmd.start_x) begin
         div_rem_ff <= '0;
         div_quo_ff <= {pos_x_ff, (OUT_W-COORD_W)'(0)};
         div_den_ff <= COUNT_WIDTH'(div_x);
      end else if (cmd.start_y) begin
         div_rem_ff <= '0;
         div_quo_ff <= {pos_y_ff, (OUT_W-COORD_W)'(0)};
         div_den_ff <= COUNT_WIDTH'(div_y);
      end else if (cmd.start_rate) begin
         // The top of the scaled numerator seeds the remainder; it is below the divisor
         // unless the rate saturates.
         div_rem_ff <= COUNT_WIDTH'(prod_ff >> SAT_SHIFT);
         div_quo_ff <= {prod_ff[SAT_SHIFT-1:0], RATE_FRAC'(0)};
         div_den_ff <= occ_ff;
      end else if (div_busy_ff) begin
         div_rem_ff <= rem_in;
         div_quo_ff <= {div_quo_ff[OUT_W-2:0], rem_fits};
      end
   end

   // Cell inside the area in use, and its store address.
   assign in_area = ({1'b0, col_ff} < 9'(map_width_ff))  && ({1'b0, col_ff} < 9'(MAP_DIM)) &&
                    ({1'b0, row_ff} < 9'(map_height_ff)) && ({1'b0, row_ff} < 9'(MAP_DIM));
   assign cell_addr = ADDR_W'(int'(row_ff) * MAP_DIM + int'(col_ff));

   // Clearing sweep address.
   assign clear_last = (clr_addr_ff == ADDR_W'(CELLS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_write) begin
         clr_addr_ff <= clear_last ? '0 : clr_addr_ff + ADDR_W'(1);
      end
   end

   // Saturating counter update from the word just read.
   assign occ_rd  = rd_data[MEM_W-1:COUNT_WIDTH];
   assign spk_rd  = rd_data[COUNT_WIDTH-1:0];
   assign occ_sum = {1'b0, occ_rd} + (COUNT_WIDTH+1)'(1);
   assign spk_sum = {1'b0, spk_rd} + (COUNT_WIDTH+1)'(spike_ff);
   assign occ_new = occ_sum[COUNT_WIDTH] ? '1 : occ_sum[COUNT_WIDTH-1:0];
   assign spk_new = spk_sum[COUNT_WIDTH] ? '1 : spk_sum[COUNT_WIDTH-1:0];

   // Store write port is shared by the clearing sweep and sample updates.
   assign wr_en   = cmd.clear_write | cmd.mem_update;
   assign wr_addr = cmd.clear_write ? clr_addr_ff : cell_addr;
   assign wr_data = cmd.clear_write ? '0 : {occ_new, spk_new};

   orm_ram #(
      .WIDTH (MEM_W),
      .DEPTH (CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.mem_read),
      .rd_addr (cell_addr),
      .rd_data (rd_data)
   );

   // Counters of the cell being read; a cell outside the area reads as empty.
   always_ff @(posedge clock) begin
      if (cmd.load_counts) begin
         occ_ff <= in_area ? occ_rd : '0;
         spk_ff <= in_area ? spk_rd : '0;
      end
      if (cmd.load_product) begin
         prod_ff <= PROD_W'(spk_ff) * PROD_W'(sps_ff);
      end
   end

   // The rate overflows Q24.8 when the integer part of the quotient needs over 24 bits.
   assign rate_sat = PROD_W'(prod_ff >> SAT_SHIFT) >= PROD_W'(occ_ff);

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         if (occ_ff == '0) begin
            rsp_ff.rate_q8 <= '0;
         end else if (rate_sat) begin
            rsp_ff.rate_q8 <= '1;
         end else begin
            rsp_ff.rate_q8 <= div_quo_ff;
         end
         rsp_ff.visited     <= (occ_ff != '0);
         rsp_ff.occupancy   <= sat_out(occ_ff);
         rsp_ff.spike_total <= sat_out(spk_ff);
      end
   end

   assign rsp_data = rsp_ff;

   assign status.command    = command_ff;
   assign status.div_busy   = div_busy_ff;
   assign status.in_area    = in_area;
   assign status.clear_last = clear_last;

endmodule

@@ src/orm_ctrl.sv @@
// Controller: sequences each command and owns the handshakes.
module orm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  orm_pkg::orm_status_type status,
   output orm_pkg::orm_cmd_type    cmd
);
   import orm_pkg::*;

   typedef enum logic [11:0] {
      ST_CLEAR    = 12'b0000_0000_0001,
      ST_IDLE     = 12'b0000_0000_0010,
      ST_DISPATCH = 12'b0000_0000_0100,
      ST_DIVX     = 12'b0000_0000_1000,
      ST_DIVY     = 12'b0000_0001_0000,
      ST_LOOKUP   = 12'b0000_0010_0000,
      ST_UPDATE   = 12'b0000_0100_0000,
      ST_FETCH    = 12'b0000_1000_0000,
      ST_MUL      = 12'b0001_0000_0000,
      ST_RATE     = 12'b0010_0000_0000,
      ST_DIVR     = 12'b0100_0000_0000,
      ST_RESULT   = 12'b1000_0000_0000
   } orm_state_type;

   orm_state_type state_ff;
   orm_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.command)
               CMD_ADD: begin
                  cmd.start_x = 1'b1;
                  state_in    = ST_DIVX;
               end
               CMD_READ:  state_in = ST_LOOKUP;
               CMD_CLEAR: state_in = ST_CLEAR;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_DIVX: begin
            if (!status.div_busy) begin
               cmd.cap_col = 1'b1;
               cmd.start_y = 1'b1;
               state_in    = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (!status.div_busy) begin
               cmd.cap_row = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.mem_read = 1'b1;
            if (status.command == CMD_ADD) begin
               // Samples outside the area in use are dropped.
               state_in = status.in_area ? ST_UPDATE : ST_IDLE;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_UPDATE: begin
            cmd.mem_update = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_FETCH: begin
            cmd.load_counts = 1'b1;
            state_in        = ST_MUL;
         end
         ST_MUL: begin
            cmd.load_product = 1'b1;
            state_in         = ST_RATE;
         end
         ST_RATE: begin
            cmd.start_rate = 1'b1;
            state_in       = ST_DIVR;
         end
         ST_DIVR: begin
            if (!status.div_busy) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // Load the output register once it is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register valid flag.
   always_comb begin
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ src/occupancy_rate_map_unit.sv @@
// Top level of the occupancy rate map: firing-rate map with saturating cell counters.
//
//   Channel | Ports                            | Moves
//   --------+----------------------------------+-------------------------------------
//   request | req_valid, req_ready, req_data   | add sample, read cell or clear
//   result  | rsp_valid, rsp_ready, rsp_data   | one rate transfer per read command
//   config  | csr_we, csr_index, csr_wdata     | register write, taken at any edge
//
// An add sample takes two 8-step passes of the shared bit-serial divider for binning,
// then a read-modify-write of the counter store.
// A read runs the 32-step rate division in the same divider.
// Reset and the clear command both start a clearing pass over all 4096 store entries,
// one entry per cycle, during which no request is taken.
// A waiting result does not hold up the next request; only the next result waits for it.
module occupancy_rate_map_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  orm_pkg::orm_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output orm_pkg::orm_rsp_type            rsp_data,
   input  logic                            csr_we,
   input  logic [orm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [orm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import orm_pkg::*;

   orm_cmd_type    cmd;
   orm_status_type status;

   orm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   orm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

   // No request is taken while the store is being cleared.
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_write |-> !req_ready)
      else $error("request taken during clearing pass");

   // A new result never overwrites one that is still waiting.
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten");

   // The store write port has one owner at a time.
   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_update |-> !cmd.clear_write)
      else $error("update collides with clearing pass");

   // Reset always leads into the clearing pass.
   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (cmd.clear_write && !req_ready))
      else $error("no clearing pass after reset");

endmodule

@@ bench/occupancy_rate_map_checker.sv @@
// Checker for the occupancy rate map: tracks the cell counters and checks every rate transfer.
module occupancy_rate_map_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  orm_pkg::orm_req_type             req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  orm_pkg::orm_rsp_type             rsp_data,
   input  logic                             csr_we,
   input  logic [orm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [orm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               error_count,
   output int                               pending_reads
);
   timeunit 1ns;
   timeprecision 1ps;
   import orm_pkg::*;

   localparam bit [63:0] COUNT_LIMIT   = (64'd1 << COUNT_WIDTH) - 64'd1;
   localparam bit [63:0] FIELD_LIMIT   = 64'hFFFF_FFFF;
   localparam bit [63:0] QUOTIENT_CAP  = 64'h00FF_FFFF;
   localparam bit [7:0]  RESET_REDUCE  = 8'd4;
   localparam bit [6:0]  RESET_SIZE    = 7'd64;
   localparam bit [15:0] RESET_SPS     = 16'd30;

   // Predicted cell counters, kept wider than the block so saturation is explicit.
   bit [63:0]   occupancy_counts [CELLS];
   bit [63:0]   spike_counts [CELLS];

   // Shadow copy of the configuration registers.
   bit [7:0]    reduce_x_reg;
   bit [7:0]    reduce_y_reg;
   bit [6:0]    width_reg;
   bit [6:0]    height_reg;
   bit [15:0]   rate_scale;

   orm_rsp_type expected_reads [$];
   orm_rsp_type oldest_read;
   int          mismatch_total = 0;

   assign error_count = mismatch_total;

   function automatic int unsigned cells_in_use(bit [6:0] size);
      return (size > MAP_DIM) ? MAP_DIM : size;
   endfunction

   function automatic bit [63:0] clip_field(bit [63:0] value);
      return (value > FIELD_LIMIT) ? FIELD_LIMIT : value;
   endfunction

   // Spikes per second in Q24.8, truncated, from a cell's two counters.
   function automatic bit [31:0] firing_rate_q8(bit [63:0] spikes, bit [63:0] occ);
      bit [63:0] scaled;
      bit [63:0] quotient;
      bit [63:0] remainder;
      bit [63:0] fixed;
      if (occ == 0) begin
         return '0;
      end
      scaled    = spikes * 64'(rate_scale);
      quotient  = scaled / occ;
      remainder = scaled % occ;
      if (quotient > QUOTIENT_CAP) begin
         return '1;
      end
      fixed = (quotient << 8) + ((remainder << 8) / occ);
      return 32'(clip_field(fixed));
   endfunction

   task automatic wipe_maps();
      for (int i = 0; i < CELLS; i++) begin
         occupancy_counts[i] = '0;
         spike_counts[i]     = '0;
      end
   endtask

   // Bin one position sample and bump that cell's counters, dropping it off the map.
   task automatic record_sample(orm_req_type item);
      int unsigned div_x;
      int unsigned div_y;
      int unsigned col;
      int unsigned row;
      int unsigned idx;
      div_x = (reduce_x_reg == 0) ? 1 : reduce_x_reg;
      div_y = (reduce_y_reg == 0) ? 1 : reduce_y_reg;
      col   = item.pos_x / div_x;
      row   = item.pos_y / div_y;
      if (col >= cells_in_use(width_reg) || row >= cells_in_use(height_reg)) begin
         return;
      end
      idx = row * MAP_DIM + col;
      if (occupancy_counts[idx] < COUNT_LIMIT) begin
         occupancy_counts[idx] += 64'd1;
      end
      if (COUNT_LIMIT - spike_counts[idx] < 64'(item.spike_count)) begin
         spike_counts[idx] = COUNT_LIMIT;
      end else begin
         spike_counts[idx] += 64'(item.spike_count);
      end
   endtask

   // Expected answer to a read of one cell; cells off the map read as all zero.
   function automatic orm_rsp_type read_prediction(logic [5:0] col, logic [5:0] row);
      orm_rsp_type result;
      bit [63:0]   occ;
      bit [63:0]   spk;
      int unsigned idx;
      occ = '0;
      spk = '0;
      if (col < cells_in_use(width_reg) && row < cells_in_use(height_reg)) begin
         idx = row * MAP_DIM + col;
         occ = occupancy_counts[idx];
         spk = spike_counts[idx];
      end
      result.rate_q8     = firing_rate_q8(spk, occ);
      result.visited     = (occ != 0);
      result.occupancy   = 32'(clip_field(occ));
      result.spike_total = 32'(clip_field(spk));
      return result;
   endfunction

   task automatic report_mismatch(string message);
      $display("%0t ns: occupancy rate map: %s", $time, message);
      mismatch_total++;
   endtask

   task automatic compare_field(string name, logic [63:0] seen, logic [63:0] wanted);
      if (seen !== wanted) begin
         report_mismatch($sformatf("%s got %0h, expected %0h", name, seen, wanted));
      end
   endtask

   // Follow register writes and accepted requests, and check each result transfer.
   always @(posedge clock) begin
      if (reset) begin
         reduce_x_reg = RESET_REDUCE;
         reduce_y_reg = RESET_REDUCE;
         width_reg    = RESET_SIZE;
         height_reg   = RESET_SIZE;
         rate_scale   = RESET_SPS;
         wipe_maps();
         expected_reads.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_REDUCE_X:   reduce_x_reg = csr_wdata[7:0];
               CSR_REDUCE_Y:   reduce_y_reg = csr_wdata[7:0];
               CSR_MAP_WIDTH:  width_reg    = csr_wdata[6:0];
               CSR_MAP_HEIGHT: height_reg   = csr_wdata[6:0];
               CSR_SPS:        rate_scale   = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_data.command)
               CMD_ADD:   record_sample(req_data);
               CMD_READ:  expected_reads.push_back(read_prediction(req_data.cell_col,
                                                                   req_data.cell_row));
               CMD_CLEAR: wipe_maps();
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_reads.size() == 0) begin
               report_mismatch("result transfer with no read outstanding");
            end else begin
               oldest_read = expected_reads.pop_front();
               compare_field("rate_q8", rsp_data.rate_q8, oldest_read.rate_q8);
               compare_field("visited", rsp_data.visited, oldest_read.visited);
               compare_field("occupancy", rsp_data.occupancy, oldest_read.occupancy);
               compare_field("spike_total", rsp_data.spike_total, oldest_read.spike_total);
            end
         end
      end
      pending_reads = expected_reads.size();
   end

endmodule

@@ bench/occupancy_rate_map_unit_test.sv @@
// Testbench top for the occupancy rate map: clock, reset, stimulus, flow control and verdict.
module occupancy_rate_map_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import orm_pkg::*;

   localparam logic [1:0] CMD_UNUSED      = 2'd3;
   localparam int         RANDOM_PHASES   = 8;
   localparam int         ITEMS_PER_PHASE = 64;
   localparam int         HOLD_PHASE      = 5;
   localparam int         STEADY_PHASE    = 6;
   localparam int         HOLD_CYCLES     = 600;
   localparam int         SETTLE_CYCLES   = 4200;
   localparam int         CYCLE_LIMIT     = 1000000;
   localparam int         RECENT_DEPTH    = 16;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   orm_req_type            req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   orm_rsp_type            rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int                     error_count;
   int                     pending_reads;

   int unsigned            cycle_count = 0;
   int unsigned            hold_count  = 0;
   bit                     hold_wanted = 1'b0;
   bit                     hold_done   = 1'b0;
   bit                     no_idle     = 1'b0;

   // Current map setup, used only to aim samples at cells on the map.
   bit [7:0]               cfg_rx = 8'd4;
   bit [7:0]               cfg_ry = 8'd4;
   bit [6:0]               cfg_w  = 7'd64;
   bit [6:0]               cfg_h  = 7'd64;
   bit [11:0]              recent_cells [$];

   occupancy_rate_map_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   occupancy_rate_map_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_reads (pending_reads)
   );

   // 50 MHz clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("occupancy_rate_map_unit_test: errors");
         $finish;
      end
   end

   // Result side: one long hold-off when asked, a steady phase, random stalls otherwise.
   always @(posedge clock) begin
      if (hold_wanted && !hold_done) begin
         rsp_ready  <= 1'b0;
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_CYCLES - 1) begin
            hold_done <= 1'b1;
         end
      end else if (no_idle) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 34);
      end
   end

   // Offer one request and return at the edge where it transfers.
   task automatic send_request(input orm_req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(negedge clock);
      while (!req_ready) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   // Random gaps between requests, skipped during the steady phase.
   task automatic pause_sender();
      if (no_idle) begin
         return;
      end
      while ($urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic offer(input orm_req_type item);
      send_request(item);
      pause_sender();
   endtask

   task automatic send_fields(input logic [1:0] command, input logic [7:0] pos_x,
                              input logic [7:0] pos_y, input logic [7:0] spikes,
                              input logic [5:0] col, input logic [5:0] row);
      orm_req_type item;
      item.command     = command;
      item.pos_x       = pos_x;
      item.pos_y       = pos_y;
      item.spike_count = spikes;
      item.cell_col    = col;
      item.cell_row    = row;
      offer(item);
   endtask

   // Let every read answer arrive, then let any add or clear pass run out.
   task automatic drain_block();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_reads != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_register(input logic [CSR_INDEX_W-1:0] index,
                               input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_map(input logic [15:0] rx, input logic [15:0] ry,
                              input logic [15:0] w, input logic [15:0] h,
                              input logic [15:0] sps);
      set_register(CSR_REDUCE_X, rx);
      set_register(CSR_REDUCE_Y, ry);
      set_register(CSR_MAP_WIDTH, w);
      set_register(CSR_MAP_HEIGHT, h);
      set_register(CSR_SPS, sps);
      csr_we <= 1'b0;
      cfg_rx = rx[7:0];
      cfg_ry = ry[7:0];
      cfg_w  = w[6:0];
      cfg_h  = h[6:0];
   endtask

   // Pick a raw position that lands in a cell on the map, favoring a few low cells.
   task automatic aim_axis(input bit [7:0] reduce, input bit [6:0] size,
                           inout logic [7:0] pos, output logic [5:0] slot, output bit hit);
      int unsigned step;
      int unsigned reach;
      int unsigned pick;
      int unsigned slack;
      step  = (reduce == 0) ? 1 : reduce;
      reach = (size > MAP_DIM) ? MAP_DIM : size;
      if (reach > 255 / step + 1) begin
         reach = 255 / step + 1;
      end
      slot = '0;
      hit  = (reach != 0);
      if (!hit) begin
         return;
      end
      if ($urandom_range(0, 1) == 0) begin
         pick = $urandom_range(0, ((reach < 4) ? reach : 4) - 1);
      end else begin
         pick = $urandom_range(0, reach - 1);
      end
      slack = 255 - pick * step;
      if (slack > step - 1) begin
         slack = step - 1;
      end
      pos  = 8'(pick * step + $urandom_range(0, slack));
      slot = 6'(pick);
   endtask

   // Mostly samples on the map and reads of cells recently hit, with some noise.
   task automatic make_request(output orm_req_type item);
      int unsigned pick;
      bit          hit_x;
      bit          hit_y;
      logic [5:0]  col;
      logic [5:0]  row;
      item.command     = CMD_ADD;
      item.pos_x       = 8'($urandom_range(0, 255));
      item.pos_y       = 8'($urandom_range(0, 255));
      item.spike_count = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
      item.cell_col    = 6'($urandom_range(0, 63));
      item.cell_row    = 6'($urandom_range(0, 63));
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         item.command = CMD_CLEAR;
      end else if (pick < 5) begin
         item.command = CMD_UNUSED;
      end else if (pick < 60) begin
         aim_axis(cfg_rx, cfg_w, item.pos_x, col, hit_x);
         aim_axis(cfg_ry, cfg_h, item.pos_y, row, hit_y);
         if (hit_x && hit_y) begin
            recent_cells.push_back({row, col});
            if (recent_cells.size() > RECENT_DEPTH) begin
               void'(recent_cells.pop_front());
            end
         end
      end else if (pick >= 65) begin
         item.command = CMD_READ;
         if (recent_cells.size() != 0 && $urandom_range(0, 9) < 7) begin
            {item.cell_row, item.cell_col} =
               recent_cells[$urandom_range(0, recent_cells.size() - 1)];
         end
      end
   endtask

   // Stimulus: reset, directed items at reset settings, then randomized phases.
   initial begin
      orm_req_type item;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Corners of the map, full and empty spike counts, unused command, clear.
      send_fields(CMD_ADD, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0);
      send_fields(CMD_ADD, 8'd3, 8'd3, 8'd255, 6'd63, 6'd63);
      send_fields(CMD_ADD, 8'd255, 8'd255, 8'd255, 6'd0, 6'd0);
      send_fields(CMD_ADD, 8'd252, 8'd0, 8'd1, 6'd0, 6'd0);
      send_fields(CMD_READ, 8'd255, 8'd255, 8'd255, 6'd0, 6'd0);
      send_fields(CMD_READ, 8'd0, 8'd0, 8'd0, 6'd63, 6'd63);
      send_fields(CMD_READ, 8'd0, 8'd0, 8'd0, 6'd63, 6'd0);
      send_fields(CMD_READ, 8'd0, 8'd0, 8'd0, 6'd1, 6'd1);
      send_fields(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 6'h3F, 6'h3F);
      send_fields(CMD_READ, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0);
      send_fields(CMD_ADD, 8'd0, 8'd255, 8'd128, 6'd0, 6'd0);
      send_fields(CMD_READ, 8'd0, 8'd0, 8'd0, 6'd0, 6'd63);
      send_fields(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0);
      send_fields(CMD_READ, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0);
      send_fields(CMD_READ, 8'd0, 8'd0, 8'd0, 6'd63, 6'd63);
      send_fields(CMD_ADD, 8'd1, 8'd2, 8'd255, 6'd0, 6'd0);
      send_fields(CMD_READ, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0);
      drain_block();

      for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
         // Fixed extremes first, then random setups with junk in the unused upper bits.
         case (phase)
            1: program_map(16'd1, 16'd1, 16'd64, 16'd64, 16'hFFFF);
            2: program_map(16'd255, 16'd255, 16'd1, 16'd1, 16'd1);
            3: program_map(16'hFF00, 16'hFF00, 16'd127, 16'd127, 16'd0);
            4: program_map(16'd3, 16'd5, 16'hFF80, 16'hFF80, 16'd1000);
            default: begin
               if (phase == HOLD_PHASE) begin
                  set_register(CSR_INDEX_W'(CSR_SPS + 3'd1), 16'($urandom));
               end
               program_map((16'($urandom_range(0, 255)) << 8) | 16'($urandom_range(1, 12)),
                           (16'($urandom_range(0, 255)) << 8) | 16'($urandom_range(1, 12)),
                           (16'($urandom_range(0, 511)) << 7) | 16'($urandom_range(1, 64)),
                           (16'($urandom_range(0, 511)) << 7) | 16'($urandom_range(1, 64)),
                           16'($urandom_range(1, 65535)));
            end
         endcase
         if (phase == HOLD_PHASE) begin
            hold_wanted <= 1'b1;
         end
         no_idle <= (phase == STEADY_PHASE);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            make_request(item);
            offer(item);
         end
         drain_block();
      end

      if (error_count == 0) begin
         $display("occupancy_rate_map_unit_test: clean");
      end else begin
         $display("occupancy_rate_map_unit_test: errors");
      end
      $finish;
   end

endmodule
